FILE: hdl/scsa_pkg.sv
// Shared types, widths and codes of the sparse column sorted accumulator.
package scsa_pkg;

    // Field widths.
    localparam int B_ROW_W   = 24;
    localparam int A_ROW_W   = 16;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 48;
    localparam int ROW_W     = 32;
    localparam int CFG_W     = 16;
    localparam int COL_W     = 16;
    localparam int RED_W     = 24;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Default number of cells in the chain.
    localparam int DEPTH_DEF = 64;

    // Request kinds.
    localparam logic REQ_TERM  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ROWS_OF_A   = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    // One input beat.
    typedef struct packed {
        logic                     req_type;
        logic [B_ROW_W-1:0]       b_row;
        logic signed [VAL_W-1:0]  b_value;
        logic [A_ROW_W-1:0]       a_row;
        logic signed [VAL_W-1:0]  a_value;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [COL_W-1:0]         column_number;
        logic [ROW_W-1:0]         out_row;
        logic signed [ACC_W-1:0]  out_value;
        logic                     entry_valid;
        logic                     overflowed;
        logic                     last_of_column;
    } result_t;

    // Operation broadcast to every cell.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_ADD,
        CELL_DRAIN
    } cell_op_t;

    // Broadcast control and term data for the cell chain.
    typedef struct packed {
        cell_op_t                 op;
        logic [ROW_W-1:0]         row;
        logic signed [ACC_W-1:0]  val;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_CMP,
        ST_INS,
        ST_DRAIN
    } state_t;

endpackage

FILE: hdl/scsa_mod.sv
// Bit-serial remainder unit: one restoring step per cycle over the B row.
module scsa_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [scsa_pkg::B_ROW_W-1:0]  dividend,
    input  logic [scsa_pkg::CFG_W-1:0]    divisor,
    output logic [scsa_pkg::CFG_W-1:0]    rem,
    output logic                          done
);
    import scsa_pkg::*;

    localparam int CNT_W = $clog2(B_ROW_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [B_ROW_W-1:0] dvd_reg;
    logic [CFG_W-1:0]   rem_reg;
    logic [CFG_W-1:0]   dsr_reg;
    logic [CFG_W:0]     trial;
    logic [CFG_W-1:0]   rem_next;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[B_ROW_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = CFG_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[CFG_W-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (load)
            begin
                cnt_reg <= CNT_W'(B_ROW_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Dividend shifter and partial remainder.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[B_ROW_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

FILE: hdl/scsa_cell.sv
// One cell of the sorted store: holds one row and its accumulated value.
module scsa_cell #(
    parameter int DEPTH = scsa_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                                clk,
    input  scsa_pkg::cell_ctrl_t                ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]          count,
    input  logic [scsa_pkg::ROW_W-1:0]          left_row,
    input  logic signed [scsa_pkg::ACC_W-1:0]   left_val,
    input  logic                                left_lt,
    input  logic [scsa_pkg::ROW_W-1:0]          right_row,
    input  logic signed [scsa_pkg::ACC_W-1:0]   right_val,
    output logic [scsa_pkg::ROW_W-1:0]          row,
    output logic signed [scsa_pkg::ACC_W-1:0]   val,
    output logic                                lt,
    output logic                                eq
);
    import scsa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic signed [ACC_W-1:0] VMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] VMIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [ROW_W-1:0]        row_reg, row_next;
    logic signed [ACC_W-1:0] val_reg, val_next;
    logic                    lt_reg, lt_next;
    logic                    eq_reg, eq_next;
    logic                    occupied;
    logic                    at_pos;
    logic                    shift_in;
    logic [ACC_W:0]          sum;
    logic signed [ACC_W-1:0] sat_sum;

    // Cells below the fill count hold live entries.
    assign occupied = (CW'(IDX) < count);

    // Insert position is the first cell not below the new row.
    assign at_pos   = !lt_reg && ((IDX == 0) || left_lt);
    assign shift_in = (IDX != 0) && !left_lt;

    // Saturating accumulate into the signed 48-bit range.
    always_comb
    begin
        sum = {val_reg[ACC_W-1], val_reg} + {ctrl.val[ACC_W-1], ctrl.val};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sat_sum = sum[ACC_W] ? VMIN : VMAX;
        end
        else
        begin
            sat_sum = sum[ACC_W-1:0];
        end
    end

    // Cell update for the broadcast operation.
    always_comb
    begin
        row_next = row_reg;
        val_next = val_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        case (ctrl.op)
            CELL_CMP:
            begin
                lt_next = occupied && (row_reg < ctrl.row);
                eq_next = occupied && (row_reg == ctrl.row);
            end
            CELL_INS:
            begin
                if (at_pos)
                begin
                    row_next = ctrl.row;
                    val_next = ctrl.val;
                end
                else if (shift_in)
                begin
                    row_next = left_row;
                    val_next = left_val;
                end
            end
            CELL_ADD:
            begin
                if (eq_reg)
                begin
                    val_next = sat_sum;
                end
            end
            CELL_DRAIN:
            begin
                if (IDX != DEPTH - 1)
                begin
                    row_next = right_row;
                    val_next = right_val;
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // Entry payload and compare flags.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        val_reg <= val_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign row = row_reg;
    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

FILE: hdl/sparse_column_sorted_accumulator.sv
// Top level of the sparse column sorted accumulator: sequencer, front end and cell chain.
//
// Usage. Items enter on the command channel: a beat is taken when start is high and busy
// is low. A term beat (req_type 0) forms the output row (b_row mod block_count) *
// rows_of_a + a_row and the rounded Q32.16 product b_value * a_value, then adds it into
// a chain of DEPTH cells kept in ascending row order, or inserts it as a new entry;
// a row that finds the chain full is dropped and sets the overflow flag. A close beat
// (req_type 1) emits the stored entries on result, one beat per cycle with result_valid
// high for exactly one cycle each; the first entry beat comes from the drain state
// through the result register, and an empty column gives one marker beat in the cycle
// right after the close. The receiver cannot stall the results. A term keeps busy high
// through the 24-step bit-serial remainder unit and the multiply, sum, compare and
// insert steps; with block_count zero the remainder unit is skipped. A close of N
// entries keeps busy high while the chain shifts toward cell 0; an empty close leaves
// busy low. The user must write the APB registers rows_of_a (address 0) and block_count
// (address 4) only while the block is idle; the block does not enforce this. Reset sets
// both to 1 and empties the store, the overflow flag and the column counter.
module sparse_column_sorted_accumulator #(
    parameter int DEPTH = scsa_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  scsa_pkg::item_t               item,
    output logic                          result_valid,
    output scsa_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scsa_pkg::APB_AW-1:0]   paddr,
    input  logic [scsa_pkg::APB_DW-1:0]   pwdata,
    output logic [scsa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import scsa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // Control state.
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  drain_left_reg;
    logic           overflow_reg;
    logic [COL_W-1:0] column_reg;
    logic           result_valid_reg;
    logic [CFG_W-1:0] rows_of_a_reg;
    logic [CFG_W-1:0] block_count_reg;

    // Datapath registers.
    logic [A_ROW_W-1:0]       a_row_reg;
    logic signed [VAL_W-1:0]  b_value_reg;
    logic signed [VAL_W-1:0]  a_value_reg;
    logic [RED_W-1:0]         red_reg;
    logic [RED_W+CFG_W-1:0]   row_prod_reg;
    logic signed [PROD_W-1:0] val_prod_reg;
    logic [ROW_W-1:0]         row_reg;
    logic signed [ACC_W-1:0]  val_reg;
    logic [COL_W-1:0]         col_snap_reg;
    logic                     ovf_snap_reg;
    result_t                  result_reg;
    logic signed [PROD_W-1:0] rnd;

    // Decoded control.
    logic       accept;
    logic       acc_term;
    logic       acc_close;
    logic       mod_load;
    logic       mod_done;
    logic [CFG_W-1:0] mod_rem;
    logic       full;
    logic       hit;
    logic       cfg_wr;
    cell_ctrl_t cell_ctrl;

    // Cell chain wiring.
    logic [ROW_W-1:0]        cell_row [DEPTH];
    logic signed [ACC_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]        cell_lt;
    logic [DEPTH-1:0]        cell_eq;

    assign accept    = start && !busy;
    assign acc_term  = accept && (item.req_type == REQ_TERM);
    assign acc_close = accept && (item.req_type == REQ_CLOSE);
    assign full      = (count_reg == CW'(DEPTH));
    assign hit       = |cell_eq;
    assign busy      = (state_reg != ST_IDLE);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? APB_DW'(block_count_reg)
                                                  : APB_DW'(rows_of_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_of_a_reg   <= CFG_W'(1);
            block_count_reg <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_BLOCK_COUNT)
            begin
                block_count_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                rows_of_a_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Remainder unit for the B row.
    scsa_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (mod_load),
        .dividend (item.b_row),
        .divisor  (block_count_reg),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_close)
                begin
                    state_next = (count_reg != '0) ? ST_DRAIN : ST_IDLE;
                end
                else if (acc_term)
                begin
                    state_next = (block_count_reg == '0) ? ST_MUL : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_INS;
            ST_INS:   state_next = ST_IDLE;
            ST_DRAIN:
            begin
                if (drain_left_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs for the remainder unit and the cell chain.
    always_comb
    begin
        mod_load      = 1'b0;
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.row = row_reg;
        cell_ctrl.val = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mod_load = acc_term && (block_count_reg != '0);
            end
            ST_CMP:
            begin
                cell_ctrl.op = CELL_CMP;
            end
            ST_INS:
            begin
                if (hit)
                begin
                    cell_ctrl.op = CELL_ADD;
                end
                else if (!full)
                begin
                    cell_ctrl.op = CELL_INS;
                end
            end
            ST_DRAIN:
            begin
                cell_ctrl.op = CELL_DRAIN;
            end
            default:
            begin
                mod_load = 1'b0;
            end
        endcase
    end

    // Store bookkeeping, column counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            drain_left_reg   <= '0;
            overflow_reg     <= 1'b0;
            column_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (acc_close && (count_reg == '0)) || (state_reg == ST_DRAIN);
            if (acc_close)
            begin
                count_reg      <= '0;
                overflow_reg   <= 1'b0;
                column_reg     <= column_reg + COL_W'(1);
                drain_left_reg <= count_reg;
            end
            else if (state_reg == ST_DRAIN)
            begin
                drain_left_reg <= drain_left_reg - CW'(1);
            end
            else if ((state_reg == ST_INS) && !hit)
            begin
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    // Rounding of the Q32.32 product to Q32.16, half up.
    assign rnd = val_prod_reg + PROD_W'(32768);

    // Front end datapath: operand latch, reduced row, products and sums.
    always_ff @(posedge clk)
    begin
        if (acc_term)
        begin
            a_row_reg   <= item.a_row;
            b_value_reg <= item.b_value;
            a_value_reg <= item.a_value;
            red_reg     <= item.b_row;
        end
        if ((state_reg == ST_DIV) && mod_done)
        begin
            red_reg <= RED_W'(mod_rem);
        end
        if (state_reg == ST_MUL)
        begin
            row_prod_reg <= (RED_W+CFG_W)'(red_reg) * (RED_W+CFG_W)'(rows_of_a_reg);
            val_prod_reg <= PROD_W'(b_value_reg) * PROD_W'(a_value_reg);
        end
        if (state_reg == ST_SUM)
        begin
            row_reg <= row_prod_reg[ROW_W-1:0] + ROW_W'(a_row_reg);
            val_reg <= rnd[PROD_W-1:16];
        end
        if (acc_close)
        begin
            col_snap_reg <= column_reg;
            ovf_snap_reg <= overflow_reg;
        end
    end

    // Result beat: an empty-column marker or the entry at the head of the chain.
    always_ff @(posedge clk)
    begin
        if (acc_close && (count_reg == '0))
        begin
            result_reg.column_number  <= column_reg;
            result_reg.out_row        <= '0;
            result_reg.out_value      <= '0;
            result_reg.entry_valid    <= 1'b0;
            result_reg.overflowed     <= overflow_reg;
            result_reg.last_of_column <= 1'b1;
        end
        else if (state_reg == ST_DRAIN)
        begin
            result_reg.column_number  <= col_snap_reg;
            result_reg.out_row        <= cell_row[0];
            result_reg.out_value      <= cell_val[0];
            result_reg.entry_valid    <= 1'b1;
            result_reg.overflowed     <= ovf_snap_reg;
            result_reg.last_of_column <= (drain_left_reg == CW'(1));
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Chain of cells, each wired to its two neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == DEPTH - 1) ? i : i + 1;

        scsa_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .count     (count_reg),
            .left_row  (cell_row[L]),
            .left_val  (cell_val[L]),
            .left_lt   (cell_lt[L]),
            .right_row (cell_row[R]),
            .right_val (cell_val[R]),
            .row       (cell_row[i]),
            .val       (cell_val[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond chain depth");

    // Every drain cycle produces a result beat in the next cycle.
    a_drain_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> result_valid)
        else $error("drain cycle without a result beat");

    // The last beat of a column leaves the sequencer idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_of_column) |-> (state_reg == ST_IDLE))
        else $error("last beat of a column while still busy");

    // An empty-column marker is always the only beat of its column.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.entry_valid) |-> result.last_of_column)
        else $error("empty marker not flagged as last");

endmodule
